### rtl/lse_pkg.sv
// Shared types and constants for the LSB steganography extractor.
// No dependencies. Used by every module of the block.
`default_nettype none

package lse_pkg;

  // One carrier image byte and its restart flag.
  typedef struct packed {
    logic [7:0] carrier_byte;
    logic       first_of_image;
  } lse_in_t;

  // One decoded result.
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
    logic        is_last;
  } lse_out_t;

  // Result kinds.
  localparam logic [1:0] KIND_LENGTH  = 2'd0;
  localparam logic [1:0] KIND_BYTE    = 2'd1;
  localparam logic [1:0] KIND_HDR_ERR = 2'd2;

  // Fixed widths of the decoder state.
  localparam int HEADER_BITS = 3;
  localparam int HDR_CNT_W   = 2;
  localparam int BPB_W       = 3;
  localparam int BUF_W       = 16;
  localparam int BUF_CNT_W   = 4;
  localparam int VALUE_W     = 32;

  // Decoder phases.
  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_LENGTH  = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_DONE    = 4'b1000
  } lse_phase_t;

endpackage

`default_nettype wire

### rtl/lse_queue.sv
// Front end: two-entry request queue that accepts carrier bytes.
// Depends on lse_pkg for the request type.
`default_nettype none

module lse_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire lse_pkg::lse_in_t in_data,
  output logic                head_valid,
  output lse_pkg::lse_in_t    head_data,
  input  wire logic           pop
);

  lse_pkg::lse_in_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  logic       do_pop;

  // Handshake on both sides of the queue.
  assign in_ready   = (count_r != 2'd2);
  assign push       = in_valid && in_ready;
  assign head_valid = (count_r != 2'd0);
  assign head_data  = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  // Pointer and fill-level update.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_data;
    end
  end

endmodule

`default_nettype wire

### rtl/lse_back.sv
// Back end: bit-stream decoder with header, length and payload phases,
// followed by the result register. Depends on lse_pkg.
`default_nettype none

module lse_back #(
  parameter int LENGTH_BITS = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             head_valid,
  input  wire lse_pkg::lse_in_t head_data,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output lse_pkg::lse_out_t     out_data
);

  localparam int LEFT_W = $clog2(LENGTH_BITS + 1);

  lse_pkg::lse_phase_t            phase_r, phase_nxt, phase_cur;
  logic [lse_pkg::HDR_CNT_W-1:0]  hdr_cnt_r, hdr_cnt_nxt, hdr_cnt_cur;
  logic [lse_pkg::BPB_W-1:0]      bpb_r, bpb_nxt, bpb_cur;
  logic [LEFT_W-1:0]              left_r, left_nxt, left_cur;
  logic [LENGTH_BITS-1:0]         acc_r, acc_nxt, acc_cur;
  logic [LENGTH_BITS-1:0]         bytes_r, bytes_nxt, bytes_cur;
  logic [lse_pkg::BUF_W-1:0]      buf_r, buf_nxt, buf_cur;
  logic [lse_pkg::BUF_CNT_W-1:0]  bcnt_r, bcnt_nxt, bcnt_cur;
  logic                           ovalid_r, ovalid_nxt;
  lse_pkg::lse_out_t              odata_r, odata_nxt;

  logic                           issue;
  logic                           res_valid;
  lse_pkg::lse_out_t              res;
  logic [7:0]                     bits8;
  logic [lse_pkg::BPB_W-1:0]      take;
  logic [lse_pkg::BPB_W-1:0]      rest;
  logic [lse_pkg::BUF_W-1:0]      merged;
  logic [lse_pkg::BUF_CNT_W-1:0]  merged_cnt;
  logic [lse_pkg::BUF_CNT_W-1:0]  left_cnt;

  // A request is taken whenever the result register is free or draining.
  assign issue     = !ovalid_r || out_ready;
  assign pop       = head_valid && issue;
  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

  // Restart flag replaces the stored state with its reset values.
  always_comb begin
    if (head_data.first_of_image) begin
      phase_cur   = lse_pkg::PH_HEADER;
      hdr_cnt_cur = '0;
      bpb_cur     = '0;
      left_cur    = LEFT_W'(LENGTH_BITS);
      acc_cur     = '0;
      bytes_cur   = '0;
      buf_cur     = '0;
      bcnt_cur    = '0;
    end else begin
      phase_cur   = phase_r;
      hdr_cnt_cur = hdr_cnt_r;
      bpb_cur     = bpb_r;
      left_cur    = left_r;
      acc_cur     = acc_r;
      bytes_cur   = bytes_r;
      buf_cur     = buf_r;
      bcnt_cur    = bcnt_r;
    end
  end

  // Low n bits of the carrier byte and the split of a length byte.
  always_comb begin
    bits8 = head_data.carrier_byte & 8'((9'd1 << bpb_cur) - 9'd1);
    if ({{LEFT_W{1'b0}}, bpb_cur} > {3'b000, left_cur}) begin
      take = lse_pkg::BPB_W'(left_cur);
    end else begin
      take = bpb_cur;
    end
    rest       = bpb_cur - take;
    merged     = (buf_cur << bpb_cur) | lse_pkg::BUF_W'(bits8);
    merged_cnt = bcnt_cur + lse_pkg::BUF_CNT_W'(bpb_cur);
    left_cnt   = merged_cnt - lse_pkg::BUF_CNT_W'(8);
  end

  // Phase sequencing and result formation.
  always_comb begin
    phase_nxt   = phase_cur;
    hdr_cnt_nxt = hdr_cnt_cur;
    bpb_nxt     = bpb_cur;
    left_nxt    = left_cur;
    acc_nxt     = acc_cur;
    bytes_nxt   = bytes_cur;
    buf_nxt     = buf_cur;
    bcnt_nxt    = bcnt_cur;
    res_valid   = 1'b0;
    res         = '0;
    case (phase_cur)
      lse_pkg::PH_HEADER: begin
        bpb_nxt     = {bpb_cur[lse_pkg::BPB_W-2:0], head_data.carrier_byte[0]};
        hdr_cnt_nxt = hdr_cnt_cur + lse_pkg::HDR_CNT_W'(1);
        if (hdr_cnt_nxt == lse_pkg::HDR_CNT_W'(lse_pkg::HEADER_BITS)) begin
          hdr_cnt_nxt = '0;
          if (bpb_nxt == '0) begin
            phase_nxt = lse_pkg::PH_DONE;
            res_valid = 1'b1;
            res.kind  = lse_pkg::KIND_HDR_ERR;
          end else begin
            phase_nxt = lse_pkg::PH_LENGTH;
          end
        end
      end
      lse_pkg::PH_LENGTH: begin
        if (bpb_cur == '0) begin
          phase_nxt = lse_pkg::PH_DONE;
        end else begin
          acc_nxt  = (acc_cur << take) | LENGTH_BITS'(bits8 >> rest);
          left_nxt = left_cur - LEFT_W'(take);
          buf_nxt  = lse_pkg::BUF_W'(bits8 & 8'((9'd1 << rest) - 9'd1));
          bcnt_nxt = lse_pkg::BUF_CNT_W'(rest);
          if (left_nxt == '0) begin
            bytes_nxt   = acc_nxt;
            res_valid   = 1'b1;
            res.kind    = lse_pkg::KIND_LENGTH;
            res.value   = lse_pkg::VALUE_W'(acc_nxt);
            res.is_last = (acc_nxt == '0);
            phase_nxt   = (acc_nxt == '0) ? lse_pkg::PH_DONE : lse_pkg::PH_PAYLOAD;
          end
        end
      end
      lse_pkg::PH_PAYLOAD: begin
        if (bpb_cur == '0) begin
          phase_nxt = lse_pkg::PH_DONE;
        end else if (merged_cnt >= lse_pkg::BUF_CNT_W'(8)) begin
          bcnt_nxt    = left_cnt;
          buf_nxt     = merged & ((lse_pkg::BUF_W'(1) << left_cnt) - lse_pkg::BUF_W'(1));
          bytes_nxt   = bytes_cur - LENGTH_BITS'(1);
          res_valid   = 1'b1;
          res.kind    = lse_pkg::KIND_BYTE;
          res.value   = lse_pkg::VALUE_W'(8'(merged >> left_cnt));
          res.is_last = (bytes_nxt == '0);
          if (bytes_nxt == '0) begin
            phase_nxt = lse_pkg::PH_DONE;
          end
        end else begin
          buf_nxt  = merged;
          bcnt_nxt = merged_cnt;
        end
      end
      lse_pkg::PH_DONE: begin
        phase_nxt = lse_pkg::PH_DONE;
      end
      default: begin
        phase_nxt = lse_pkg::PH_DONE;
      end
    endcase
  end

  // Result register loads whenever it is free or being taken.
  always_comb begin
    ovalid_nxt = ovalid_r;
    odata_nxt  = odata_r;
    if (issue) begin
      ovalid_nxt = pop && res_valid;
      odata_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= lse_pkg::PH_HEADER;
      hdr_cnt_r <= '0;
      bpb_r     <= '0;
      left_r    <= LEFT_W'(LENGTH_BITS);
      acc_r     <= '0;
      bytes_r   <= '0;
      buf_r     <= '0;
      bcnt_r    <= '0;
      ovalid_r  <= 1'b0;
    end else begin
      if (pop) begin
        phase_r   <= phase_nxt;
        hdr_cnt_r <= hdr_cnt_nxt;
        bpb_r     <= bpb_nxt;
        left_r    <= left_nxt;
        acc_r     <= acc_nxt;
        bytes_r   <= bytes_nxt;
        buf_r     <= buf_nxt;
        bcnt_r    <= bcnt_nxt;
      end
      ovalid_r <= ovalid_nxt;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    odata_r <= odata_nxt;
  end

endmodule

`default_nettype wire

### rtl/lsb_stego_extractor_unit.sv
// Path: an accepted request is written into the queue; from the queue head the
// decoder loads any result into the result register, which presents it until taken.
// Throughput: one byte per cycle while the queue has room; the decoder retires one
// queued request per cycle whenever the result register is free or being taken.
// Reset: synchronous active-low rst_n empties the queue and result register and
// returns the decoder to the header phase. Built from lse_queue and lse_back (lse_pkg).
`default_nettype none

module lsb_stego_extractor_unit #(
  parameter int LENGTH_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire lse_pkg::lse_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output lse_pkg::lse_out_t      out_data
);

  logic             head_valid;
  lse_pkg::lse_in_t head_data;
  logic             pop;

  // Front end: accept and hold carrier bytes.
  lse_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop)
  );

  // Back end: decode the bit stream and present results.
  lse_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire
